[hw/rtl/rc4ks_pkg.sv]
// shared types and constants for the rc4 keystream generator
// no dependencies
`default_nettype none

package rc4ks_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int IDX_W         = 8;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 7;
    localparam int MAX_BURST_DEF = 64;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } perm_wr_t;

endpackage

`default_nettype wire

[hw/rtl/rc4_keystream_generator.sv]
// rc4 keystream generator top level: sequencer around one shared byte adder
// load: each item stores a seed byte; the 256th load runs the key schedule over all entries
// read: per byte, step i, update j, swap s[i]/s[j], read output; holds while output is full
// not ready while a key schedule or a read burst runs; load items never produce output
// aresetn synchronous active low: perm table reads as zero, indexes and load position cleared
// depends on rc4ks_pkg and rc4ks_perm_ram
`default_nettype none

module rc4_keystream_generator #(
    parameter int MAX_BURST = rc4ks_pkg::MAX_BURST_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // seed_byte[7:0], byte_count[14:8], zero pad
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // rand_byte[7:0]
    output logic             m_axis_tlast
);
    import rc4ks_pkg::*;

    localparam int CNT_W = $clog2(MAX_BURST + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WJ,
        ST_KS_WI,
        ST_G_RD,
        ST_G_J,
        ST_G_WJ,
        ST_G_WI,
        ST_G_RO,
        ST_G_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  lp_reg, lp_next;
    logic [BYTE_W-1:0] a_reg, a_next;   // s[i]
    logic [BYTE_W-1:0] b_reg, b_next;   // s[j]
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic [BYTE_W-1:0] key_mem [TABLE_DEPTH];
    logic [BYTE_W-1:0] key_data_reg;
    logic              key_we;

    perm_wr_t          perm_wr;
    logic [IDX_W-1:0]  perm_rd_addr;
    logic [BYTE_W-1:0] perm_rd_data;

    logic [BYTE_W-1:0] add_a, add_b, add_c, add_sum;

    logic              in_fire;
    logic              in_mode;
    logic [BYTE_W-1:0] in_seed;
    logic [COUNT_W-1:0] in_count, in_count_sat;
    logic              out_free;

    assign in_mode  = s_axis_tuser;
    assign in_seed  = s_axis_tdata[7:0];
    assign in_count = s_axis_tdata[14:8];
    assign in_count_sat = (in_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : in_count;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    rc4ks_perm_ram u_perm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (perm_wr),
        .rd_addr (perm_rd_addr),
        .rd_data (perm_rd_data)
    );

    // key store is fully written before the schedule ever reads it
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[lp_reg] <= in_seed;
        end
        key_data_reg <= key_mem[k_reg];
    end

    // shared byte adder
    assign add_sum = add_a + add_b + add_c;

    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        lp_next      = lp_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        key_we       = 1'b0;
        perm_wr      = '0;
        perm_rd_addr = k_reg;
        add_a        = '0;
        add_b        = '0;
        add_c        = '0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                add_a = lp_reg;
                add_b = 8'd1;
                if (in_fire) begin
                    if (in_mode == MODE_LOAD) begin
                        key_we       = 1'b1;
                        perm_wr.en   = 1'b1;
                        perm_wr.addr = lp_reg;
                        perm_wr.data = in_seed;
                        lp_next      = add_sum;
                        if (lp_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_KS_RD;
                        end
                    end else if (in_count_sat != '0) begin
                        cnt_next   = CNT_W'(in_count_sat);
                        state_next = ST_G_RD;
                    end
                end
            end
            ST_KS_RD: begin
                perm_rd_addr = k_reg;
                state_next   = ST_KS_J;
            end
            ST_KS_J: begin
                add_a        = j_reg;
                add_b        = perm_rd_data;
                add_c        = key_data_reg;
                a_next       = perm_rd_data;
                j_next       = add_sum;
                perm_rd_addr = add_sum;
                state_next   = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                b_next       = perm_rd_data;
                perm_wr.en   = 1'b1;
                perm_wr.addr = j_reg;
                perm_wr.data = a_reg;
                state_next   = ST_KS_WI;
            end
            ST_KS_WI: begin
                add_a        = k_reg;
                add_b        = 8'd1;
                perm_wr.en   = 1'b1;
                perm_wr.addr = k_reg;
                perm_wr.data = b_reg;
                k_next       = add_sum;
                if (k_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    i_next     = '0;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_KS_RD;
                end
            end
            ST_G_RD: begin
                add_a        = i_reg;
                add_b        = 8'd1;
                i_next       = add_sum;
                perm_rd_addr = add_sum;
                state_next   = ST_G_J;
            end
            ST_G_J: begin
                add_a        = j_reg;
                add_b        = perm_rd_data;
                a_next       = perm_rd_data;
                j_next       = add_sum;
                perm_rd_addr = add_sum;
                state_next   = ST_G_WJ;
            end
            ST_G_WJ: begin
                b_next       = perm_rd_data;
                perm_wr.en   = 1'b1;
                perm_wr.addr = i_reg;
                perm_wr.data = perm_rd_data;
                state_next   = ST_G_WI;
            end
            ST_G_WI: begin
                perm_wr.en   = 1'b1;
                perm_wr.addr = j_reg;
                perm_wr.data = a_reg;
                state_next   = ST_G_RO;
            end
            ST_G_RO: begin
                add_a        = a_reg;
                add_b        = b_reg;
                perm_rd_addr = add_sum;
                state_next   = ST_G_OUT;
            end
            ST_G_OUT: begin
                // keep reading the output entry until the output register frees up
                add_a        = a_reg;
                add_b        = b_reg;
                perm_rd_addr = add_sum;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = perm_rd_data;
                    m_last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next     = cnt_reg - CNT_W'(1);
                    state_next   = (cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_G_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            lp_reg      <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            lp_reg      <= lp_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

[hw/rtl/rc4ks_perm_ram.sv]
// permutation table memory with per-entry valid bits, registered read
// depends on rc4ks_pkg
`default_nettype none

module rc4ks_perm_ram (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rc4ks_pkg::perm_wr_t       wr,
    input  wire logic [rc4ks_pkg::IDX_W-1:0]  rd_addr,
    output logic      [rc4ks_pkg::BYTE_W-1:0] rd_data
);
    import rc4ks_pkg::*;

    logic [BYTE_W-1:0]      mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [BYTE_W-1:0]      rd_mem_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

`default_nettype wire
